// ===== sv/bce_pkg.sv =====
// ----------------------------------------------------------------------------
// Bezier curve evaluator package
// Shared constants, action codes and the result type.
// ----------------------------------------------------------------------------
`default_nettype none
package bce_pkg;
  localparam int unsigned MaxPoints = 16;
  localparam int unsigned IdxW = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam logic [16:0] TOne = 17'd65536;
  localparam logic [16:0] PickRadiusSq = 17'd43264;
  localparam logic signed [15:0] EmptyCoord = -16'sd16;

  localparam logic [1:0] ActWrite = 2'd0;
  localparam logic [1:0] ActEval  = 2'd1;
  localparam logic [1:0] ActPick  = 2'd2;

  typedef struct packed {
    logic        found;
    logic [3:0]  index;
    logic signed [15:0] x;
    logic signed [15:0] y;
  } result_t;
endpackage
`default_nettype wire

// ===== sv/bce_store.sv =====
// ----------------------------------------------------------------------------
// Bezier point store
// Synchronous memory of control points, one write and one read port,
// read data registered.
// ----------------------------------------------------------------------------
`default_nettype none
module bce_store (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [bce_pkg::IdxW-1:0]  waddr_i,
  input  wire logic [31:0]               wdata_i,
  input  wire logic [bce_pkg::IdxW-1:0]  raddr_i,
  output logic [31:0]                    rdata_o
);
  logic [31:0] mem [bce_pkg::MaxPoints];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== sv/bezier_curve_evaluator.sv =====
// A write, an unused action, and an evaluation or a pick on an empty curve go straight to
// the done state; a pick reads the stored points in order and stops at the first hit.
// An evaluation first copies the active points into the scratch memory, then per level
// passes through two read states (StRdA, StRdB) and per interpolation through StMul and StWr.
// One request at a time: the input stalls until the result has reached the output
// register. Reset clears the state machine, point_count and the output; the store is not reset.
// ----------------------------------------------------------------------------
// Bezier curve evaluator
// Point store plus a scratch memory reworked in place by de Casteljau steps.
// ----------------------------------------------------------------------------
`default_nettype none
module bezier_curve_evaluator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_wdata_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [3:0]  point_index_i,
  input  wire logic signed [15:0] coord_x_i,
  input  wire logic signed [15:0] coord_y_i,
  input  wire logic [16:0] param_t_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic signed [15:0] out_x_o,
  output logic signed [15:0] out_y_o,
  output logic             hit_found_o,
  output logic [3:0]       hit_index_o
);
  localparam int unsigned IW = bce_pkg::IdxW;
  localparam int unsigned CW = bce_pkg::CntW;

  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StLoad  = 8'b00000010,
    StRdA   = 8'b00000100,
    StRdB   = 8'b00001000,
    StMul   = 8'b00010000,
    StWr    = 8'b00100000,
    StPick  = 8'b01000000,
    StDone  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [4:0] count_q;
  logic [CW-1:0] n_q;
  logic signed [15:0] qx_q, qy_q;
  logic [16:0] t_q;
  logic [CW-1:0] i_q;       // sweep / element index
  logic [CW-1:0] lvl_q;     // interpolations at this level
  logic rd_pend_q;          // a store read is in flight
  logic rd_issue;
  logic [CW-1:0] ri_q;      // index that read belongs to
  logic signed [15:0] ax_q, ay_q;
  logic signed [33:0] px_q, py_q;
  bce_pkg::result_t res_q, res_d;
  bce_pkg::result_t out_q;
  logic ovalid_q;
  logic accept;

  // Active count, clamped to the store depth.
  logic [CW-1:0] n_act;
  always_comb begin
    if (32'(count_q) > bce_pkg::MaxPoints) n_act = CW'(bce_pkg::MaxPoints);
    else n_act = CW'(count_q);
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // Point store.
  logic st_we;
  logic [IW-1:0] st_raddr;
  logic [31:0] st_rdata;
  assign accept = in_valid_i && !in_stall_o;
  assign st_we = accept && (action_i == bce_pkg::ActWrite) &&
                 (32'(point_index_i) < bce_pkg::MaxPoints);
  bce_store u_store (
    .clk_i  (clk_i),
    .we_i   (st_we),
    .waddr_i(IW'(point_index_i)),
    .wdata_i({coord_y_i, coord_x_i}),
    .raddr_i(st_raddr),
    .rdata_o(st_rdata)
  );

  // Scratch memory for de Casteljau work values.
  logic [31:0] wk_mem [bce_pkg::MaxPoints];
  logic wk_we;
  logic [IW-1:0] wk_waddr, wk_raddr;
  logic [31:0] wk_wdata, wk_rdata;
  always_ff @(posedge clk_i) begin
    if (wk_we) wk_mem[wk_waddr] <= wk_wdata;
    wk_rdata <= wk_mem[wk_raddr];
  end

  // Interpolation arithmetic: difference times t, rounded half up.
  logic signed [15:0] bx, by;
  logic signed [16:0] dx, dy;
  assign bx = wk_rdata[15:0];
  assign by = wk_rdata[31:16];
  assign dx = 17'(bx) - 17'(ax_q);
  assign dy = 17'(by) - 17'(ay_q);
  logic signed [17:0] tq;
  assign tq = {1'b0, t_q};
  logic signed [33:0] lx, ly;
  assign lx = ((px_q + 34'sd32768) >>> 16) + 34'(ax_q);
  assign ly = ((py_q + 34'sd32768) >>> 16) + 34'(ay_q);

  // Pick distance from the store data.
  logic signed [16:0] ex, ey;
  logic [33:0] dist_sq;
  assign ex = 17'(signed'(st_rdata[15:0])) - 17'(qx_q);
  assign ey = 17'(signed'(st_rdata[31:16])) - 17'(qy_q);
  assign dist_sq = 34'(ex * ex) + 34'(ey * ey);

  assign in_stall_o = (state_q != StIdle);
  assign st_raddr = IW'(i_q);
  assign rd_issue = ((state_q == StLoad) || (state_q == StPick)) && (i_q < n_q);

  // Control and datapath sequencing.
  always_comb begin
    state_d = state_q;
    res_d = res_q;
    wk_we = 1'b0;
    wk_waddr = IW'(ri_q);
    wk_wdata = st_rdata;
    wk_raddr = IW'(i_q);
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          res_d = '0;
          if (action_i == bce_pkg::ActEval) begin
            res_d.x = bce_pkg::EmptyCoord;
            res_d.y = bce_pkg::EmptyCoord;
            if (n_act != '0) state_d = StLoad;
            else state_d = StDone;
          end else if (action_i == bce_pkg::ActPick && n_act != '0) begin
            state_d = StPick;
          end else begin
            state_d = StDone;
          end
        end
      end
      StLoad: begin
        wk_we = rd_pend_q;
        if (rd_pend_q && (ri_q == n_q - CW'(1))) begin
          if (n_q == CW'(1)) begin
            res_d.x = signed'(st_rdata[15:0]);
            res_d.y = signed'(st_rdata[31:16]);
            state_d = StDone;
          end else begin
            state_d = StRdA;
          end
        end
      end
      StRdA: state_d = StRdB;
      StRdB: begin
        wk_raddr = IW'(i_q + CW'(1));
        state_d = StMul;
      end
      StMul: begin
        // Hold the address so the right-hand entry stays on the read data.
        wk_raddr = IW'(i_q + CW'(1));
        state_d = StWr;
      end
      StWr: begin
        wk_we = 1'b1;
        wk_waddr = IW'(i_q);
        wk_wdata = {ly[15:0], lx[15:0]};
        wk_raddr = IW'(i_q + CW'(2));
        if (i_q + CW'(1) == lvl_q) begin
          if (lvl_q == CW'(1)) begin
            res_d.x = lx[15:0];
            res_d.y = ly[15:0];
            state_d = StDone;
          end else begin
            state_d = StRdA;
          end
        end else begin
          state_d = StMul;
        end
      end
      StPick: begin
        if (rd_pend_q && dist_sq <= 34'(bce_pkg::PickRadiusSq)) begin
          res_d.found = 1'b1;
          res_d.index = 4'(ri_q);
          state_d = StDone;
        end else if (rd_pend_q && ri_q == n_q - CW'(1)) begin
          state_d = StDone;
        end
      end
      StDone: if (!ovalid_q || !out_stall_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // State, read tracking and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovalid_q <= 1'b0;
      rd_pend_q <= 1'b0;
      out_q <= '0;
    end else begin
      state_q <= state_d;
      rd_pend_q <= rd_issue;
      if (state_q == StDone && state_d == StIdle) begin
        ovalid_q <= 1'b1;
        out_q <= res_q;
      end else if (ovalid_q && !out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // Payload and index registers.
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    ri_q <= i_q;
    if (accept) begin
      n_q <= n_act;
      qx_q <= coord_x_i;
      qy_q <= coord_y_i;
      t_q <= (param_t_i > bce_pkg::TOne) ? bce_pkg::TOne : param_t_i;
      i_q <= '0;
      lvl_q <= n_act - CW'(1);
    end else begin
      unique case (state_q)
        StLoad: begin
          if (state_d != StLoad) i_q <= '0;
          else if (i_q < n_q) i_q <= i_q + CW'(1);
        end
        StPick: if (i_q < n_q) i_q <= i_q + CW'(1);
        StRdB: begin
          // The left-hand entry of the level arrives now.
          ax_q <= signed'(wk_rdata[15:0]);
          ay_q <= signed'(wk_rdata[31:16]);
        end
        StMul: begin
          px_q <= 34'(dx * tq);
          py_q <= 34'(dy * tq);
        end
        StWr: begin
          // The right-hand entry becomes the left one of the next step.
          ax_q <= bx;
          ay_q <= by;
          if (i_q + CW'(1) == lvl_q) begin
            lvl_q <= lvl_q - CW'(1);
            i_q <= '0;
          end else begin
            i_q <= i_q + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = ovalid_q;
  assign out_x_o = out_q.x;
  assign out_y_o = out_q.y;
  assign hit_found_o = out_q.found;
  assign hit_index_o = out_q.index;
endmodule
`default_nettype wire

// ===== sv/bce_checker.sv =====
// ----------------------------------------------------------------------------
// Bezier evaluator port checker
// Checks the handshake behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
`default_nettype none
module bce_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic hit_found_o,
  input wire logic [3:0] hit_index_o
);
  // A stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o) else $error("result dropped");
  // An accepted request blocks the input next cycle.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("input not busy");
  // A result without a hit carries index zero.
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_found_o |-> hit_index_o == 4'd0) else $error("stray index");
endmodule

bind bezier_curve_evaluator bce_checker u_bce_checker (.*);
`default_nettype wire

// ===== bench/bezier_curve_evaluator_tb.sv =====
// ----------------------------------------------------------------------------
// Bezier curve evaluator testbench
// Drives point writes, curve evaluations, picks and unused actions through the
// request port under random idling and stalls. A scoreboard keeps its own copy
// of the point store and the point count, predicts every response, and compares
// each accepted response field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

class bezier_scoreboard;
  localparam int unsigned Stores = bce_pkg::MaxPoints;

  logic signed [15:0] px [Stores];
  logic signed [15:0] py [Stores];
  logic [4:0]         point_count;
  bce_pkg::result_t   expected_q [$];
  bit                 failed;

  function new();
    point_count = '0;
    failed = 1'b0;
  endfunction

  // One de Casteljau step with round half up.
  function automatic logic signed [15:0] blend(logic signed [15:0] a,
                                               logic signed [15:0] b,
                                               logic [16:0] t);
    longint prod;
    prod = (longint'(b) - longint'(a)) * longint'(t) + 32768;
    return 16'(longint'(a) + (prod >>> 16));
  endfunction

  // Works out the response of one accepted request and queues it.
  function void note_request(logic [1:0] act, logic [3:0] idx,
                             logic signed [15:0] cx, logic signed [15:0] cy,
                             logic [16:0] t);
    bce_pkg::result_t  r;
    int unsigned       n;
    logic signed [15:0] wx [Stores];
    logic signed [15:0] wy [Stores];
    longint            dx, dy;
    logic [16:0]       tc;
    r = '0;
    n = (point_count > Stores) ? Stores : point_count;
    tc = (t > bce_pkg::TOne) ? bce_pkg::TOne : t;
    case (act)
      bce_pkg::ActWrite: begin
        px[idx] = cx;
        py[idx] = cy;
      end
      bce_pkg::ActEval: begin
        if (n == 0) begin
          r.x = bce_pkg::EmptyCoord;
          r.y = bce_pkg::EmptyCoord;
        end else begin
          for (int i = 0; i < n; i++) begin
            wx[i] = px[i];
            wy[i] = py[i];
          end
          for (int lvl = n - 1; lvl > 0; lvl--) begin
            for (int i = 0; i < lvl; i++) begin
              wx[i] = blend(wx[i], wx[i + 1], tc);
              wy[i] = blend(wy[i], wy[i + 1], tc);
            end
          end
          r.x = wx[0];
          r.y = wy[0];
        end
      end
      bce_pkg::ActPick: begin
        for (int i = 0; i < n; i++) begin
          dx = longint'(px[i]) - longint'(cx);
          dy = longint'(py[i]) - longint'(cy);
          if (!r.found && dx * dx + dy * dy <= longint'(bce_pkg::PickRadiusSq)) begin
            r.found = 1'b1;
            r.index = 4'(i);
          end
        end
      end
      default: ;
    endcase
    expected_q.push_back(r);
  endfunction

  // Compares one accepted response with the oldest prediction.
  function void check_result(bce_pkg::result_t got);
    bce_pkg::result_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: unexpected response x=%0d y=%0d found=%0b index=%0d",
               $time, got.x, got.y, got.found, got.index);
      failed = 1'b1;
      return;
    end
    want = expected_q.pop_front();
    if (got.x !== want.x) begin
      $display("%0t: out_x expected %0d actual %0d", $time, want.x, got.x);
      failed = 1'b1;
    end
    if (got.y !== want.y) begin
      $display("%0t: out_y expected %0d actual %0d", $time, want.y, got.y);
      failed = 1'b1;
    end
    if (got.found !== want.found) begin
      $display("%0t: hit_found expected %0b actual %0b", $time, want.found, got.found);
      failed = 1'b1;
    end
    if (got.index !== want.index) begin
      $display("%0t: hit_index expected %0d actual %0d", $time, want.index, got.index);
      failed = 1'b1;
    end
  endfunction
endclass

module bezier_curve_evaluator_tb;
  localparam logic [1:0] ActNone = 2'd3;
  localparam int unsigned PhaseItems = 120;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [4:0]        cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        action_i;
  logic [3:0]        point_index_i;
  logic signed [15:0] coord_x_i;
  logic signed [15:0] coord_y_i;
  logic [16:0]       param_t_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic signed [15:0] out_x_o;
  logic signed [15:0] out_y_o;
  logic              hit_found_o;
  logic [3:0]        hit_index_o;

  bezier_scoreboard sb;
  bit               sender_idles;
  bit               receiver_idles;
  bit               hold_request;

  bezier_curve_evaluator DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .action_i     (action_i),
    .point_index_i(point_index_i),
    .coord_x_i    (coord_x_i),
    .coord_y_i    (coord_y_i),
    .param_t_i    (param_t_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .hit_found_o  (hit_found_o),
    .hit_index_o  (hit_index_o)
  );

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog for a hung run.
  initial begin
    #60000000;
    $display("[bezier_curve_evaluator] ERROR");
    $finish;
  end

  // Response side: random stalls, an occasional long hold, and checking.
  initial begin : response_side
    int unsigned stall_left;
    int unsigned hold_left;
    bce_pkg::result_t got;
    stall_left = 0;
    hold_left = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.x = out_x_o;
        got.y = out_y_o;
        got.found = hit_found_o;
        got.index = hit_index_o;
        sb.check_result(got);
        stall_left = receiver_idles ? $urandom_range(0, 6) : 0;
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = 600;
      end
      out_stall_i <= (hold_left > 0) || (stall_left > 0);
      if (hold_left > 0) hold_left--;
      if (stall_left > 0) stall_left--;
    end
  end

  // Sends one request and notes it in the scoreboard once accepted.
  task automatic send_request(logic [1:0] act, logic [3:0] idx,
                              logic signed [15:0] cx, logic signed [15:0] cy,
                              logic [16:0] t);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    point_index_i <= idx;
    coord_x_i <= cx;
    coord_y_i <= cy;
    param_t_i <= t;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(act, idx, cx, cy, t);
  endtask

  // Waits until every predicted response has come back, then lets the block settle.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Register write while the block is idle.
  task automatic set_point_count(logic [4:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.point_count = value;
  endtask

  // One random request; picks mostly aim near a stored point.
  task automatic random_request();
    int unsigned pick;
    int unsigned j;
    logic signed [15:0] cx, cy;
    logic [16:0] t;
    pick = $urandom_range(0, 99);
    cx = 16'($urandom());
    cy = 16'($urandom());
    case ($urandom_range(0, 3))
      0: t = 17'($urandom_range(0, 65536));
      1: t = 17'($urandom());
      2: t = ($urandom_range(0, 1) != 0) ? 17'd0 : bce_pkg::TOne;
      default: t = 17'($urandom_range(0, 131071));
    endcase
    if (pick < 20) begin
      if ($urandom_range(0, 3) == 0) begin
        cx = 16'($signed($urandom_range(0, 64)) - 32);
        cy = 16'($signed($urandom_range(0, 64)) - 32);
      end
      send_request(bce_pkg::ActWrite, 4'($urandom()), cx, cy, t);
    end else if (pick < 60) begin
      send_request(bce_pkg::ActEval, 4'($urandom()), cx, cy, t);
    end else if (pick < 95) begin
      if ($urandom_range(0, 3) != 0) begin
        j = $urandom_range(0, bce_pkg::MaxPoints - 1);
        cx = sb.px[j] + 16'($signed($urandom_range(0, 440)) - 220);
        cy = sb.py[j] + 16'($signed($urandom_range(0, 440)) - 220);
      end
      send_request(bce_pkg::ActPick, 4'($urandom()), cx, cy, t);
    end else begin
      send_request(ActNone, 4'($urandom()), cx, cy, t);
    end
  endtask

  // Main sequence.
  initial begin : stimulus
    logic [4:0] counts [8];
    sb = new();
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    hold_request = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    action_i = '0;
    point_index_i = '0;
    coord_x_i = '0;
    coord_y_i = '0;
    param_t_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty curve: evaluation gives minus sixteen, a pick finds nothing; an unused action follows.
    set_point_count(5'd0);
    send_request(bce_pkg::ActEval, 4'd0, 16'sd0, 16'sd0, 17'd32768);
    send_request(bce_pkg::ActPick, 4'd0, 16'sd0, 16'sd0, 17'd0);
    send_request(ActNone, 4'hF, 16'h7FFF, -16'sd32768, 17'h1FFFF);

    // Fill the whole store, extremes included.
    send_request(bce_pkg::ActWrite, 4'd0, 16'sh7FFF, -16'sd32768, 17'd0);
    send_request(bce_pkg::ActWrite, 4'd1, -16'sd32768, 16'sh7FFF, 17'd0);
    for (int i = 2; i < bce_pkg::MaxPoints; i++)
      send_request(bce_pkg::ActWrite, 4'(i), 16'($urandom()), 16'($urandom()), 17'd0);
    drain();

    // Two points at the extremes, parameter at ends, middle and beyond one; picks at the radius edge and far off.
    set_point_count(5'd2);
    send_request(bce_pkg::ActEval, 4'd0, 16'sd0, 16'sd0, 17'd0);
    send_request(bce_pkg::ActEval, 4'd0, 16'sd0, 16'sd0, bce_pkg::TOne);
    send_request(bce_pkg::ActEval, 4'd0, 16'sd0, 16'sd0, 17'd32768);
    send_request(bce_pkg::ActEval, 4'd0, 16'sd0, 16'sd0, 17'h1FFFF);
    send_request(bce_pkg::ActPick, 4'd0, 16'sh7FFF - 16'sd208, -16'sd32768, 17'd0);
    send_request(bce_pkg::ActPick, 4'd0, 16'sh7FFF - 16'sd209, -16'sd32768, 17'd0);
    send_request(bce_pkg::ActPick, 4'd0, 16'sd0, 16'sd0, 17'd0);
    drain();

    // Random phases over several point counts; a count above the store size is clamped.
    counts = '{5'd31, 5'd16, 5'd1, 5'd3, 5'd0, 5'd5, 5'd17, 5'd8};
    foreach (counts[p]) begin
      set_point_count(counts[p]);
      sender_idles = (p % 3) != 2;
      receiver_idles = (p % 4) != 3;
      if (p == 5) hold_request = 1'b1;
      for (int k = 0; k < PhaseItems; k++) random_request();
      drain();
    end

    // A random small count to close out.
    set_point_count(5'($urandom_range(0, 6)));
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    for (int k = 0; k < 40; k++) random_request();
    drain();

    if (sb.failed || sb.expected_q.size() != 0) begin
      $display("[bezier_curve_evaluator] ERROR");
    end else begin
      $display("[bezier_curve_evaluator] OK");
    end
    $finish;
  end
endmodule

`default_nettype wire
